[rtl/ggi_pkg.sv]
package ggi_pkg;

   localparam int MAX_N     = 30;
   localparam int SAMPLE_W  = 32;
   localparam int FRAC_W    = 16;
   localparam int GRAD_W    = SAMPLE_W + 4;
   localparam int POS_W     = 22;
   localparam int COORD_W   = 6;
   localparam int SIZE_W    = 5;
   localparam int DIM_W     = $clog2(MAX_N + 2);
   localparam int ADDR_W    = 3 * DIM_W;
   localparam int DEPTH     = 2 ** ADDR_W;
   localparam int CSR_IDX_W = 2;
   localparam int CRD_EXT_W = COORD_W + 1;
   localparam int DIFF_W    = GRAD_W + 1;
   localparam int PROD_W    = DIFF_W + FRAC_W + 1;

   // result status, also used as the item class in the queue
   localparam logic [1:0] ST_WRITE     = 2'd0;
   localparam logic [1:0] ST_QUERY     = 2'd1;
   localparam logic [1:0] ST_BAD_QUERY = 2'd2;
   localparam logic [1:0] ST_BAD_WRITE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_N);

   // tap weights of the difference stencils
   localparam logic [2:0] CF_ZERO = 3'd0;
   localparam logic [2:0] CF_P1   = 3'd1;
   localparam logic [2:0] CF_M1   = 3'd2;
   localparam logic [2:0] CF_P3   = 3'd3;
   localparam logic [2:0] CF_M3   = 3'd4;
   localparam logic [2:0] CF_P4   = 3'd5;
   localparam logic [2:0] CF_M4   = 3'd6;

   typedef struct packed {
      logic [1:0]                       kind;
      logic [ADDR_W-1:0]                addr;
      logic [SAMPLE_W-1:0]              sample;
      logic [2:0][COORD_W-1:0]          lo;
      logic [2:0][FRAC_W-1:0]           wt;
      logic [2:0][SIZE_W-1:0]           n;
   } ggi_item_type;

   // blend schedule: y lerps into slots 0,1,4,5, then x into 0,4, then z
   function automatic logic [2:0] blend_a(input logic [2:0] step);
      logic [2:0] r;
      case (step)
         3'd0: r = 3'd0;
         3'd1: r = 3'd1;
         3'd2: r = 3'd4;
         3'd3: r = 3'd5;
         3'd4: r = 3'd0;
         3'd5: r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] blend_b(input logic [2:0] step);
      logic [2:0] r;
      case (step)
         3'd0: r = 3'd2;
         3'd1: r = 3'd3;
         3'd2: r = 3'd6;
         3'd3: r = 3'd7;
         3'd4: r = 3'd1;
         3'd5: r = 3'd5;
         default: r = 3'd4;
      endcase
      return r;
   endfunction

endpackage

[rtl/ggi_if.sv]
interface ggi_req_if;
   import ggi_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic signed [COORD_W-1:0]   node_x;
   logic signed [COORD_W-1:0]   node_y;
   logic signed [COORD_W-1:0]   node_z;
   logic signed [SAMPLE_W-1:0]  sample_value;
   logic signed [POS_W-1:0]     pos_x;
   logic signed [POS_W-1:0]     pos_y;
   logic signed [POS_W-1:0]     pos_z;
   modport source (output valid, func, node_x, node_y, node_z, sample_value,
                   pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, func, node_x, node_y, node_z, sample_value,
                   pos_x, pos_y, pos_z, output ready);
endinterface

interface ggi_rsp_if;
   import ggi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [GRAD_W-1:0]  grad_x;
   logic signed [GRAD_W-1:0]  grad_y;
   logic signed [GRAD_W-1:0]  grad_z;
   logic [1:0]                status;
   modport source (output valid, grad_x, grad_y, grad_z, status, input ready);
   modport sink   (input valid, grad_x, grad_y, grad_z, status, output ready);
endinterface

[rtl/ggi_ram.sv]
module ggi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(DEPTH)-1:0]  addr,
   input  logic [WIDTH-1:0]          wdata,
   output logic [WIDTH-1:0]          rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
endmodule

[rtl/ggi_front.sv]
module ggi_front (
   input  logic                           clock,
   input  logic                           reset,
   ggi_req_if.sink                        req_chan,
   input  logic                           csr_we,
   input  logic [ggi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ggi_pkg::SIZE_W-1:0]     csr_wdata,
   input  logic                           pop,
   output logic                           head_valid,
   output ggi_pkg::ggi_item_type          head
);
   import ggi_pkg::*;

   logic [2:0][SIZE_W-1:0]   size_ff, size_in;
   logic [2:0][SIZE_W-1:0]   n_eff;
   ggi_item_type             item;
   ggi_item_type             q_ff [2];
   ggi_item_type             q_in [2];
   logic                     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]               count_ff, count_in;
   logic                     push;
   logic signed [COORD_W-1:0]   nd [3];
   logic signed [POS_W-1:0]     ps [3];
   logic signed [COORD_W-1:0]   lo [3];
   logic signed [CRD_EXT_W-1:0] lim [3];
   logic                     w_ok, q_ok;

   // size registers; the sizes in use are clamped into [2, MAX_N]
   always_comb begin
      size_in = size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SIZE_X: size_in[0] = csr_wdata;
            CSR_SIZE_Y: size_in[1] = csr_wdata;
            CSR_SIZE_Z: size_in[2] = csr_wdata;
            default: ;
         endcase
      end
      for (int i = 0; i < 3; i++) begin
         if (size_ff[i] < SIZE_W'(2)) begin
            n_eff[i] = SIZE_W'(2);
         end else if (size_ff[i] > SIZE_W'(MAX_N)) begin
            n_eff[i] = SIZE_W'(MAX_N);
         end else begin
            n_eff[i] = size_ff[i];
         end
      end
   end

   // classify the beat
   always_comb begin
      nd[0] = req_chan.node_x;
      nd[1] = req_chan.node_y;
      nd[2] = req_chan.node_z;
      ps[0] = req_chan.pos_x;
      ps[1] = req_chan.pos_y;
      ps[2] = req_chan.pos_z;
      w_ok = 1'b1;
      q_ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (nd[i] < -1 || nd[i] > MAX_N) begin
            w_ok = 1'b0;
         end
         lo[i]  = COORD_W'(ps[i] >>> FRAC_W);
         lim[i] = $signed({2'b00, n_eff[i]}) - CRD_EXT_W'(1);
         if (lo[i] < -1 || CRD_EXT_W'(lo[i]) > lim[i]) begin
            q_ok = 1'b0;
         end
         item.lo[i] = lo[i];
         item.wt[i] = ps[i][FRAC_W-1:0];
         item.n[i]  = n_eff[i];
      end
      item.addr   = {DIM_W'(nd[2] + COORD_W'(1)), DIM_W'(nd[1] + COORD_W'(1)),
                     DIM_W'(nd[0] + COORD_W'(1))};
      item.sample = req_chan.sample_value;
      if (req_chan.func) begin
         item.kind = q_ok ? ST_QUERY : ST_BAD_QUERY;
      end else begin
         item.kind = w_ok ? ST_WRITE : ST_BAD_WRITE;
      end
   end

   // two-entry queue towards the back end
   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign head_valid     = (count_ff != 2'd0);
   assign head           = q_ff[rd_ptr_ff];

   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         q_in[wr_ptr_ff] = item;
         wr_ptr_in       = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         size_ff   <= {3{SIZE_RESET}};
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         size_ff   <= size_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

[rtl/ggi_back.sv]
module ggi_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  ggi_pkg::ggi_item_type          head,
   output logic                           pop,
   output logic                           ram_we,
   output logic [ggi_pkg::ADDR_W-1:0]     ram_addr,
   output logic [ggi_pkg::SAMPLE_W-1:0]   ram_wdata,
   input  logic [ggi_pkg::SAMPLE_W-1:0]   ram_rdata,
   ggi_rsp_if.source                      rsp_chan
);
   import ggi_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_BLEND = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]               state_ff, state_in;
   ggi_item_type             cur_ff, cur_in;
   logic [1:0]               axis_ff, axis_in;
   logic [2:0]               corner_ff, corner_in;
   logic [1:0]               tap_ff, tap_in;
   logic                     tag_valid_ff, tag_valid_in;
   logic [2:0]               tag_coeff_ff, tag_coeff_in;
   logic                     tag_first_ff, tag_first_in;
   logic                     tag_last_ff, tag_last_in;
   logic [2:0]               tag_corner_ff, tag_corner_in;
   logic signed [GRAD_W-1:0] acc_ff, acc_in;
   logic signed [GRAD_W-1:0] d_ff [8];
   logic signed [GRAD_W-1:0] d_in [8];
   logic [2:0]               step_ff, step_in;
   logic                     phase_ff, phase_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [GRAD_W-1:0] a_ff, a_in;
   logic signed [GRAD_W-1:0] grad_ff [3];
   logic signed [GRAD_W-1:0] grad_in [3];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [GRAD_W-1:0] rsp_g_ff [3];
   logic signed [GRAD_W-1:0] rsp_g_in [3];
   logic [1:0]               rsp_st_ff, rsp_st_in;

   logic signed [CRD_EXT_W-1:0] cc [3];
   logic signed [CRD_EXT_W-1:0] nc [3];
   logic signed [CRD_EXT_W-1:0] t, nn, off;
   logic [2:0]                  coeff;
   logic                        fwd, bwd;
   logic [ADDR_W-1:0]           rd_addr;
   logic signed [GRAD_W-1:0]    v, term;
   logic signed [GRAD_W-1:0]    ba, bb;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [FRAC_W:0]      wsel;
   logic signed [GRAD_W-1:0]    res;

   // stencil node address for the current axis, corner and tap
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cc[i] = $signed({cur_ff.lo[i][COORD_W-1], cur_ff.lo[i]})
                 + $signed({{COORD_W{1'b0}}, corner_ff[i]});
      end
      t   = cc[axis_ff];
      nn  = $signed({2'b00, cur_ff.n[axis_ff]});
      fwd = (t == -1);
      bwd = (t == nn);
      off   = '0;
      coeff = CF_ZERO;
      case (tap_ff)
         2'd0: begin
            off   = (fwd || bwd) ? CRD_EXT_W'(0) : CRD_EXT_W'(1);
            coeff = fwd ? CF_M3 : (bwd ? CF_P3 : CF_P1);
         end
         2'd1: begin
            off   = fwd ? CRD_EXT_W'(1) : -CRD_EXT_W'(1);
            coeff = fwd ? CF_P4 : (bwd ? CF_M4 : CF_M1);
         end
         2'd2: begin
            off   = fwd ? CRD_EXT_W'(2) : (bwd ? -CRD_EXT_W'(2) : CRD_EXT_W'(0));
            coeff = fwd ? CF_M1 : (bwd ? CF_P1 : CF_ZERO);
         end
         default: begin
            off   = '0;
            coeff = CF_ZERO;
         end
      endcase
      nc = cc;
      nc[axis_ff] = t + off;
      rd_addr = {DIM_W'(nc[2] + CRD_EXT_W'(1)), DIM_W'(nc[1] + CRD_EXT_W'(1)),
                 DIM_W'(nc[0] + CRD_EXT_W'(1))};
   end

   // weighted tap from the memory read data
   always_comb begin
      v = GRAD_W'($signed(ram_rdata));
      case (tag_coeff_ff)
         CF_P1:   term = v;
         CF_M1:   term = -v;
         CF_P3:   term = (v <<< 1) + v;
         CF_M3:   term = -((v <<< 1) + v);
         CF_P4:   term = v <<< 2;
         CF_M4:   term = -(v <<< 2);
         default: term = '0;
      endcase
   end

   // shared lerp unit: subtract and multiply, then shift and add
   always_comb begin
      ba   = d_ff[blend_a(step_ff)];
      bb   = d_ff[blend_b(step_ff)];
      diff = DIFF_W'(bb) - DIFF_W'(ba);
      if (step_ff < 3'd4) begin
         wsel = $signed({1'b0, cur_ff.wt[1]});
      end else if (step_ff < 3'd6) begin
         wsel = $signed({1'b0, cur_ff.wt[0]});
      end else begin
         wsel = $signed({1'b0, cur_ff.wt[2]});
      end
      prod_in = PROD_W'(wsel) * PROD_W'(diff);
      res     = a_ff + GRAD_W'(prod_ff >>> FRAC_W);
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      axis_in       = axis_ff;
      corner_in     = corner_ff;
      tap_in        = tap_ff;
      tag_valid_in  = 1'b0;
      tag_coeff_in  = coeff;
      tag_first_in  = (tap_ff == 2'd0);
      tag_last_in   = (tap_ff == 2'd2);
      tag_corner_in = corner_ff;
      acc_in        = acc_ff;
      d_in          = d_ff;
      step_in       = step_ff;
      phase_in      = phase_ff;
      a_in          = a_ff;
      grad_in       = grad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_g_in      = rsp_g_ff;
      rsp_st_in     = rsp_st_ff;
      pop           = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = rd_addr;
      ram_wdata     = head.sample;

      if (tag_valid_ff) begin
         acc_in = (tag_first_ff ? '0 : acc_ff) + term;
         if (tag_last_ff) begin
            d_in[tag_corner_ff] = acc_in;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop       = 1'b1;
               cur_in    = head;
               axis_in   = 2'd0;
               corner_in = 3'd0;
               tap_in    = 2'd0;
               for (int i = 0; i < 3; i++) begin
                  grad_in[i] = '0;
               end
               if (head.kind == ST_QUERY) begin
                  state_in = S_READ;
               end else begin
                  if (head.kind == ST_WRITE) begin
                     ram_we   = 1'b1;
                     ram_addr = head.addr;
                  end
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            tag_valid_in = 1'b1;
            if (tap_ff == 2'd2) begin
               tap_in    = 2'd0;
               corner_in = corner_ff + 3'd1;
               if (corner_ff == 3'd7) begin
                  state_in = S_DRAIN;
               end
            end else begin
               tap_in = tap_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            step_in  = 3'd0;
            phase_in = 1'b0;
            state_in = S_BLEND;
         end
         S_BLEND: begin
            if (!phase_ff) begin
               a_in     = ba;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (step_ff == 3'd6) begin
                  grad_in[axis_ff] = res;
                  if (axis_ff == 2'd2) begin
                     state_in = S_DONE;
                  end else begin
                     axis_in   = axis_ff + 2'd1;
                     corner_in = 3'd0;
                     tap_in    = 2'd0;
                     state_in  = S_READ;
                  end
               end else begin
                  d_in[blend_a(step_ff)] = res;
                  step_in = step_ff + 3'd1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_g_in     = grad_ff;
               rsp_st_in    = cur_ff.kind;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      corner_ff     <= corner_in;
      tap_ff        <= tap_in;
      tag_coeff_ff  <= tag_coeff_in;
      tag_first_ff  <= tag_first_in;
      tag_last_ff   <= tag_last_in;
      tag_corner_ff <= tag_corner_in;
      acc_ff        <= acc_in;
      d_ff          <= d_in;
      step_ff       <= step_in;
      phase_ff      <= phase_in;
      prod_ff       <= prod_in;
      a_ff          <= a_in;
      grad_ff       <= grad_in;
      rsp_g_ff      <= rsp_g_in;
      rsp_st_ff     <= rsp_st_in;
      axis_ff       <= axis_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         tag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tag_valid_ff <= tag_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.grad_x = rsp_g_ff[0];
   assign rsp_chan.grad_y = rsp_g_ff[1];
   assign rsp_chan.grad_z = rsp_g_ff[2];
   assign rsp_chan.status = rsp_st_ff;
endmodule

[rtl/grid_gradient_interpolator.sv]
// Gradient of a sampled 3-D field at a fixed-point position.
//
// req_chan: one beat per item. func 0 stores sample_value at node
//   (node_x, node_y, node_z), -1 being the lower ghost layer; func 1 asks for
//   the three gradient numerators at (pos_x, pos_y, pos_z), 16 fraction bits.
// rsp_chan: exactly one beat per request, in order. status tells write done,
//   query done, query off the grid or write index off the grid; gradient
//   fields are zero for everything but a good query.
// csr_*: size_x, size_y, size_z at indexes 0..2; write only while idle.
//
// A query makes 72 reads (3 axes x 8 corners x 3 stencil taps) on the
// single grid memory port, one axis at a time, each axis followed by 7
// lerps on a shared multiplier. Writes and rejected items go from the
// queue head through the done state into the response register.
// A two-beat queue parts the front end from the worker, so new beats are
// taken while a query runs; a stalled response beat holds in its register
// and the worker waits behind it.
// Reset clears control state and sets all sizes to 30; grid contents are
// undefined until written, and queries must touch written nodes only.
module grid_gradient_interpolator (
   input  logic                           clock,
   input  logic                           reset,
   ggi_req_if.sink                        req_chan,
   ggi_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [ggi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ggi_pkg::SIZE_W-1:0]     csr_wdata
);
   import ggi_pkg::*;

   logic                 head_valid;
   logic                 pop;
   ggi_item_type         head;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_addr;
   logic [SAMPLE_W-1:0]  ram_wdata;
   logic [SAMPLE_W-1:0]  ram_rdata;

   // classify, range check, queue
   ggi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // stencil reads, trilinear blend, response register
   ggi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .ram_we     (ram_we),
      .ram_addr   (ram_addr),
      .ram_wdata  (ram_wdata),
      .ram_rdata  (ram_rdata),
      .rsp_chan   (rsp_chan)
   );

   // grid store, 32 nodes per axis including both ghost layers
   ggi_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock    (clock),
      .we       (ram_we),
      .addr     (ram_addr),
      .wdata    (ram_wdata),
      .rdata_ff (ram_rdata)
   );
endmodule

[rtl/ggi_checker.sv]
module ggi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ggi_pkg::GRAD_W-1:0] grad_x,
   input logic signed [ggi_pkg::GRAD_W-1:0] grad_y,
   input logic signed [ggi_pkg::GRAD_W-1:0] grad_z,
   input logic [1:0]                        status
);
   import ggi_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(grad_x))
      else $error("stalled response beat changed");

   a_zero_grad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_QUERY |-> grad_x == 0 && grad_y == 0 && grad_z == 0)
      else $error("non-query beat carries a gradient");
endmodule

bind grid_gradient_interpolator ggi_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .grad_x    (rsp_chan.grad_x),
   .grad_y    (rsp_chan.grad_y),
   .grad_z    (rsp_chan.grad_z),
   .status    (rsp_chan.status)
);
